@@ sv/sdts_pkg.sv @@
// Shared types and constants for the SPI descriptor transfer sequencer.
// No dependencies; used by the sequencer, its checker and the testbench.
`default_nettype none

package sdts_pkg;

  // Size of the descriptor table and width of a descriptor length.
  localparam int MaxBlocks  = 16;
  localparam int LengthBits = 16;

  // Fixed field widths of the request and result ports.
  localparam int IndexW  = 4;
  localparam int CountW  = 5;
  localparam int OffsetW = 16;
  localparam int ByteW   = 8;

  // Derived internal widths.
  localparam int AddrW = (MaxBlocks > 1) ? $clog2(MaxBlocks) : 1;
  localparam int SlotW = $clog2(MaxBlocks + 1);

  localparam logic [ByteW-1:0] DummyByte = 8'hFF;

  typedef enum logic [1:0] {
    ACT_WRITE     = 2'd0,
    ACT_START     = 2'd1,
    ACT_XFER_DONE = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    KIND_SHIFT = 2'd0,
    KIND_STORE = 2'd1,
    KIND_DONE  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_NEXT,
    ST_ADV,
    ST_ADV_WAIT
  } state_e;

  // One descriptor table entry as stored in the RAM.
  typedef struct packed {
    logic                  has_rx;
    logic                  has_tx;
    logic [LengthBits-1:0] length;
  } desc_t;

endpackage

`default_nettype wire

@@ sv/sdts_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the descriptor table of the sequencer.
`default_nettype none

module sdts_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                       wdata_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ sv/spi_descriptor_transfer_sequencer.sv @@
// Top level of the SPI descriptor transfer sequencer.
// Depends on sdts_pkg and sdts_ram (descriptor table storage).
//
//   channel   | handshake            | payload
//   ----------+----------------------+---------------------------------------------
//   request   | start, busy          | action_i, desc_index_i, desc_length_i,
//             |                      | desc_has_tx_i, desc_has_rx_i, block_count_i,
//             |                      | rx_byte_i
//   result    | strobe_o (1 cycle)   | kind_o, block_index_o, byte_offset_o,
//             |                      | data_byte_o, from_memory_o, last_o
//
// A descriptor write is done in the cycle that accepts it. A byte completion
// that stays in the current descriptor passes through ST_NEXT. Moving to another
// descriptor runs ST_ADV and ST_ADV_WAIT per table entry examined, set by the
// single read port of the descriptor RAM, up to MaxBlocks entries per scan.
// Reset clears all control state; the table is undefined until written.
// Results are shown for exactly one cycle and cannot be held off.
`default_nettype none

module spi_descriptor_transfer_sequencer (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    action_i,
  input  wire logic [sdts_pkg::IndexW-1:0]   desc_index_i,
  input  wire logic [15:0]                   desc_length_i,
  input  wire logic                          desc_has_tx_i,
  input  wire logic                          desc_has_rx_i,
  input  wire logic [sdts_pkg::CountW-1:0]   block_count_i,
  input  wire logic [sdts_pkg::ByteW-1:0]    rx_byte_i,
  output logic                               strobe_o,
  output logic [1:0]                         kind_o,
  output logic [sdts_pkg::IndexW-1:0]        block_index_o,
  output logic [sdts_pkg::OffsetW-1:0]       byte_offset_o,
  output logic [sdts_pkg::ByteW-1:0]         data_byte_o,
  output logic                               from_memory_o,
  output logic                               last_o
);

  localparam int AddrW   = sdts_pkg::AddrW;
  localparam int SlotW   = sdts_pkg::SlotW;
  localparam int LenW    = sdts_pkg::LengthBits;
  localparam int IndexW  = sdts_pkg::IndexW;
  localparam int OffsetW = sdts_pkg::OffsetW;
  localparam int ByteW   = sdts_pkg::ByteW;

  sdts_pkg::state_e state_q, state_d;

  logic             active_q, active_d;
  logic [SlotW-1:0] blocks_rem_q, blocks_rem_d;
  logic [SlotW-1:0] next_slot_q, next_slot_d;
  logic [AddrW-1:0] cur_block_q, cur_block_d;
  logic [LenW-1:0]  bytes_left_q, bytes_left_d;
  logic [OffsetW-1:0] offset_q, offset_d;
  logic             tx_q, tx_d;
  logic             rx_q, rx_d;

  logic                  strobe_q, strobe_d;
  sdts_pkg::kind_e       kind_q, kind_d;
  logic [IndexW-1:0]     blk_q, blk_d;
  logic [OffsetW-1:0]    off_q, off_d;
  logic [ByteW-1:0]      data_q, data_d;
  logic                  mem_q, mem_d;
  logic                  last_q, last_d;

  logic            ram_we;
  sdts_pkg::desc_t ram_wdata;
  sdts_pkg::desc_t ram_rdata;

  logic            accept;
  logic            slots_exhausted;
  logic            index_in_range;
  logic [SlotW-1:0] count_clamped;

  assign busy   = (state_q != sdts_pkg::ST_IDLE);
  assign accept = start && !busy;

  assign slots_exhausted = (blocks_rem_q == '0) || (next_slot_q >= SlotW'(sdts_pkg::MaxBlocks));
  assign index_in_range  = (32'(desc_index_i) < sdts_pkg::MaxBlocks);
  assign count_clamped   = (32'(block_count_i) > sdts_pkg::MaxBlocks) ?
                           SlotW'(sdts_pkg::MaxBlocks) : SlotW'(block_count_i);

  assign ram_wdata.has_rx = desc_has_rx_i;
  assign ram_wdata.has_tx = desc_has_tx_i;
  assign ram_wdata.length = LenW'(desc_length_i);

  sdts_ram #(
    .Width($bits(sdts_pkg::desc_t)),
    .Depth(sdts_pkg::MaxBlocks)
  ) u_desc_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(AddrW'(desc_index_i)),
    .wdata_i(ram_wdata),
    .raddr_i(next_slot_q[AddrW-1:0]),
    .rdata_o(ram_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sdts_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (action_i)
            sdts_pkg::ACT_START: begin
              if (!active_q) state_d = sdts_pkg::ST_ADV;
            end
            sdts_pkg::ACT_XFER_DONE: begin
              if (active_q) state_d = sdts_pkg::ST_NEXT;
            end
            default: state_d = sdts_pkg::ST_IDLE;
          endcase
        end
      end
      sdts_pkg::ST_NEXT: begin
        state_d = (bytes_left_q == '0) ? sdts_pkg::ST_ADV : sdts_pkg::ST_IDLE;
      end
      sdts_pkg::ST_ADV: begin
        state_d = slots_exhausted ? sdts_pkg::ST_IDLE : sdts_pkg::ST_ADV_WAIT;
      end
      sdts_pkg::ST_ADV_WAIT: begin
        state_d = (ram_rdata.length == '0) ? sdts_pkg::ST_ADV : sdts_pkg::ST_IDLE;
      end
      default: state_d = sdts_pkg::ST_IDLE;
    endcase
  end

  // Datapath updates, table writes and result generation.
  always_comb begin
    active_d     = active_q;
    blocks_rem_d = blocks_rem_q;
    next_slot_d  = next_slot_q;
    cur_block_d  = cur_block_q;
    bytes_left_d = bytes_left_q;
    offset_d     = offset_q;
    tx_d         = tx_q;
    rx_d         = rx_q;
    ram_we       = 1'b0;
    strobe_d     = 1'b0;
    kind_d       = kind_q;
    blk_d        = blk_q;
    off_d        = off_q;
    data_d       = data_q;
    mem_d        = mem_q;
    last_d       = last_q;

    unique case (state_q)
      sdts_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (action_i)
            sdts_pkg::ACT_WRITE: begin
              ram_we = !active_q && index_in_range;
            end
            sdts_pkg::ACT_START: begin
              if (!active_q) begin
                blocks_rem_d = count_clamped;
                next_slot_d  = '0;
              end
            end
            sdts_pkg::ACT_XFER_DONE: begin
              // The store is always followed by a shift or a done.
              if (active_q && rx_q) begin
                strobe_d = 1'b1;
                kind_d   = sdts_pkg::KIND_STORE;
                blk_d    = IndexW'(cur_block_q);
                off_d    = offset_q;
                data_d   = rx_byte_i;
                mem_d    = 1'b0;
                last_d   = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      sdts_pkg::ST_NEXT: begin
        if (bytes_left_q != '0) begin
          bytes_left_d = bytes_left_q - LenW'(1);
          offset_d     = offset_q + OffsetW'(1);
          strobe_d     = 1'b1;
          kind_d       = sdts_pkg::KIND_SHIFT;
          blk_d        = IndexW'(cur_block_q);
          off_d        = offset_q + OffsetW'(1);
          data_d       = tx_q ? '0 : sdts_pkg::DummyByte;
          mem_d        = tx_q;
          last_d       = 1'b1;
        end
      end
      sdts_pkg::ST_ADV: begin
        if (slots_exhausted) begin
          blocks_rem_d = '0;
          active_d     = 1'b0;
          strobe_d     = 1'b1;
          kind_d       = sdts_pkg::KIND_DONE;
          blk_d        = '0;
          off_d        = '0;
          data_d       = '0;
          mem_d        = 1'b0;
          last_d       = 1'b1;
        end
      end
      sdts_pkg::ST_ADV_WAIT: begin
        blocks_rem_d = blocks_rem_q - SlotW'(1);
        next_slot_d  = next_slot_q + SlotW'(1);
        if (ram_rdata.length != '0) begin
          active_d     = 1'b1;
          cur_block_d  = next_slot_q[AddrW-1:0];
          bytes_left_d = ram_rdata.length - LenW'(1);
          offset_d     = '0;
          tx_d         = ram_rdata.has_tx;
          rx_d         = ram_rdata.has_rx;
          strobe_d     = 1'b1;
          kind_d       = sdts_pkg::KIND_SHIFT;
          blk_d        = IndexW'(next_slot_q[AddrW-1:0]);
          off_d        = '0;
          data_d       = ram_rdata.has_tx ? '0 : sdts_pkg::DummyByte;
          mem_d        = ram_rdata.has_tx;
          last_d       = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= sdts_pkg::ST_IDLE;
      active_q     <= 1'b0;
      blocks_rem_q <= '0;
      next_slot_q  <= '0;
      cur_block_q  <= '0;
      bytes_left_q <= '0;
      offset_q     <= '0;
      tx_q         <= 1'b0;
      rx_q         <= 1'b0;
      strobe_q     <= 1'b0;
    end else begin
      state_q      <= state_d;
      active_q     <= active_d;
      blocks_rem_q <= blocks_rem_d;
      next_slot_q  <= next_slot_d;
      cur_block_q  <= cur_block_d;
      bytes_left_q <= bytes_left_d;
      offset_q     <= offset_d;
      tx_q         <= tx_d;
      rx_q         <= rx_d;
      strobe_q     <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    blk_q  <= blk_d;
    off_q  <= off_d;
    data_q <= data_d;
    mem_q  <= mem_d;
    last_q <= last_d;
  end

  assign strobe_o      = strobe_q;
  assign kind_o        = kind_q;
  assign block_index_o = blk_q;
  assign byte_offset_o = off_q;
  assign data_byte_o   = data_q;
  assign from_memory_o = mem_q;
  assign last_o        = last_q;

endmodule

`default_nettype wire

@@ sv/sdts_checker.sv @@
// Port-level assertions for the SPI descriptor transfer sequencer.
// Depends on sdts_pkg; bound to spi_descriptor_transfer_sequencer below.
`default_nettype none

module sdts_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        busy,
  input wire logic                        strobe_o,
  input wire logic [1:0]                  kind_o,
  input wire logic [sdts_pkg::IndexW-1:0] block_index_o,
  input wire logic [sdts_pkg::OffsetW-1:0] byte_offset_o,
  input wire logic [sdts_pkg::ByteW-1:0]  data_byte_o,
  input wire logic                        from_memory_o,
  input wire logic                        last_o
);

  // A store is never the final result of a request: a shift or done follows.
  a_store_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && (kind_o == sdts_pkg::KIND_STORE) |-> !last_o && busy)
    else $error("store result marked last or shown while idle");

  // Once the final result of a request is out, the block takes requests again.
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && last_o |-> !busy)
    else $error("final result shown while still busy");

  a_done_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && (kind_o == sdts_pkg::KIND_DONE) |->
      (block_index_o == '0) && (byte_offset_o == '0) && (data_byte_o == '0) &&
      !from_memory_o && last_o)
    else $error("done result carries payload");

  a_mem_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && (kind_o == sdts_pkg::KIND_SHIFT) |->
      (from_memory_o ? (data_byte_o == '0) : (data_byte_o == sdts_pkg::DummyByte)))
    else $error("shift data does not match its source");

endmodule

bind spi_descriptor_transfer_sequencer sdts_checker u_sdts_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .busy         (busy),
  .strobe_o     (strobe_o),
  .kind_o       (kind_o),
  .block_index_o(block_index_o),
  .byte_offset_o(byte_offset_o),
  .data_byte_o  (data_byte_o),
  .from_memory_o(from_memory_o),
  .last_o       (last_o)
);

`default_nettype wire

@@ bench/spi_descriptor_transfer_sequencer_tb.sv @@
// Self-checking testbench for spi_descriptor_transfer_sequencer.
// Depends on sdts_pkg and the sequencer RTL; the expected shift, store and done
// commands come from a behavioral copy of the sequencer kept inside this file.
module spi_descriptor_transfer_sequencer_tb;
  import sdts_pkg::*;

  // Action code that the block leaves unused.
  localparam logic [1:0] ActUnused = 2'd3;
  localparam int TargetRequests = 1350;

  typedef struct packed {
    logic [1:0]            action;
    logic [IndexW-1:0]     index;
    logic [15:0]           length;
    logic                  tx;
    logic                  rx;
    logic [CountW-1:0]     count;
    logic [ByteW-1:0]      rx_byte;
  } spi_req_t;

  typedef struct packed {
    kind_e                 kind;
    logic [IndexW-1:0]     blk;
    logic [OffsetW-1:0]    offset;
    logic [ByteW-1:0]      data;
    logic                  mem;
    logic                  last;
  } spi_cmd_t;

  typedef struct {
    spi_req_t req;
    bit       typed;
    int       n_typed;
    spi_cmd_t cmd;
  } directed_row_t;

  localparam spi_cmd_t NoCmd = '0;
  localparam spi_cmd_t DoneCmd = '{kind: KIND_DONE, blk: '0, offset: '0, data: '0,
                                   mem: 1'b0, last: 1'b1};
  localparam spi_cmd_t FirstMemShift = '{kind: KIND_SHIFT, blk: '0, offset: '0,
                                         data: '0, mem: 1'b1, last: 1'b1};

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic [1:0]           action_i;
  logic [IndexW-1:0]    desc_index_i;
  logic [15:0]          desc_length_i;
  logic                 desc_has_tx_i;
  logic                 desc_has_rx_i;
  logic [CountW-1:0]    block_count_i;
  logic [ByteW-1:0]     rx_byte_i;
  logic                 strobe_o;
  logic [1:0]           kind_o;
  logic [IndexW-1:0]    block_index_o;
  logic [OffsetW-1:0]   byte_offset_o;
  logic [ByteW-1:0]     data_byte_o;
  logic                 from_memory_o;
  logic                 last_o;

  spi_descriptor_transfer_sequencer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .action_i      (action_i),
    .desc_index_i  (desc_index_i),
    .desc_length_i (desc_length_i),
    .desc_has_tx_i (desc_has_tx_i),
    .desc_has_rx_i (desc_has_rx_i),
    .block_count_i (block_count_i),
    .rx_byte_i     (rx_byte_i),
    .strobe_o      (strobe_o),
    .kind_o        (kind_o),
    .block_index_o (block_index_o),
    .byte_offset_o (byte_offset_o),
    .data_byte_o   (data_byte_o),
    .from_memory_o (from_memory_o),
    .last_o        (last_o)
  );

  // Behavioral copy of the sequencer state.
  logic [LengthBits-1:0] desc_len [MaxBlocks];
  logic                  desc_tx  [MaxBlocks];
  logic                  desc_rx  [MaxBlocks];
  int                    runs_left;
  int                    scan_slot;
  logic [IndexW-1:0]     cur_blk;
  logic [15:0]           bytes_to_go;
  logic [OffsetW-1:0]    cur_off;
  logic                  cur_tx;
  logic                  cur_rx;
  bit                    run_active;

  spi_cmd_t      step_cmds[$];
  spi_cmd_t      expected_cmds[$];
  directed_row_t directed_rows[$];
  int            items_sent;
  int            mismatches;
  spi_cmd_t      seen_cmd;
  spi_cmd_t      want_cmd;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  function automatic string cmd_text(spi_cmd_t c);
    return $sformatf("kind=%0d blk=%0d off=%0d data=%02h mem=%0b last=%0b",
                     c.kind, c.blk, c.offset, c.data, c.mem, c.last);
  endfunction

  function automatic void note_failure(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  function automatic void push_shift();
    step_cmds.push_back('{kind: KIND_SHIFT, blk: cur_blk, offset: cur_off,
                          data: cur_tx ? 8'h00 : DummyByte, mem: cur_tx, last: 1'b0});
  endfunction

  // Skips empty descriptors, then loads the next one and commands its first
  // shift, or finishes the run when the count or the table is used up.
  function automatic void next_descriptor();
    while (runs_left != 0 && scan_slot < MaxBlocks && desc_len[scan_slot] == '0) begin
      runs_left--;
      scan_slot++;
    end
    if (runs_left == 0 || scan_slot >= MaxBlocks) begin
      runs_left = 0;
      run_active = 1'b0;
      step_cmds.push_back(DoneCmd);
    end else begin
      cur_blk = IndexW'(scan_slot);
      bytes_to_go = desc_len[scan_slot] - 1'b1;
      cur_off = '0;
      cur_tx = desc_tx[scan_slot];
      cur_rx = desc_rx[scan_slot];
      scan_slot++;
      runs_left--;
      run_active = 1'b1;
      push_shift();
    end
  endfunction

  function automatic void sequence_outputs(spi_req_t r);
    step_cmds.delete();
    case (r.action)
      ACT_WRITE: begin
        if (!run_active) begin
          desc_len[r.index] = r.length;
          desc_tx[r.index] = r.tx;
          desc_rx[r.index] = r.rx;
        end
      end
      ACT_START: begin
        if (!run_active) begin
          runs_left = (r.count > MaxBlocks) ? MaxBlocks : int'(r.count);
          scan_slot = 0;
          next_descriptor();
        end
      end
      ACT_XFER_DONE: begin
        if (run_active) begin
          if (cur_rx)
            step_cmds.push_back('{kind: KIND_STORE, blk: cur_blk, offset: cur_off,
                                  data: r.rx_byte, mem: 1'b0, last: 1'b0});
          if (bytes_to_go == '0) begin
            next_descriptor();
          end else begin
            bytes_to_go--;
            cur_off++;
            push_shift();
          end
        end
      end
      default: ;
    endcase
    if (step_cmds.size() > 0) step_cmds[step_cmds.size()-1].last = 1'b1;
  endfunction

  function automatic spi_req_t make_req(logic [1:0] act, int idx, int len, bit tx, bit rx,
                                        int cnt, int rxb);
    spi_req_t r;
    r.action = act;
    r.index = IndexW'(idx);
    r.length = 16'(len);
    r.tx = tx;
    r.rx = rx;
    r.count = CountW'(cnt);
    r.rx_byte = ByteW'(rxb);
    return r;
  endfunction

  function automatic spi_req_t random_request(logic [1:0] act);
    logic [63:0] bits;
    spi_req_t    r;
    bits = {$urandom, $urandom};
    r = bits[$bits(spi_req_t)-1:0];
    r.action = act;
    return r;
  endfunction

  // Presents one request, waits for the block to take it and records what it
  // should answer. Typed rows supply their own expectation instead.
  task automatic send_request(input spi_req_t r, input bit typed);
    int idle_pct;
    idle_pct = (items_sent >= 500 && items_sent < 800) ? 0 : 29;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    if (!start) start <= 1'b1;
    action_i      <= r.action;
    desc_index_i  <= r.index;
    desc_length_i <= r.length;
    desc_has_tx_i <= r.tx;
    desc_has_rx_i <= r.rx;
    block_count_i <= r.count;
    rx_byte_i     <= r.rx_byte;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    sequence_outputs(r);
    if (!typed) foreach (step_cmds[i]) expected_cmds.push_back(step_cmds[i]);
    items_sent++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && strobe_o) begin
      seen_cmd = '{kind: kind_e'(kind_o), blk: block_index_o, offset: byte_offset_o,
                   data: data_byte_o, mem: from_memory_o, last: last_o};
      if (expected_cmds.size() == 0) begin
        note_failure({"unexpected result: ", cmd_text(seen_cmd)});
      end else begin
        want_cmd = expected_cmds.pop_front();
        if (seen_cmd.kind !== want_cmd.kind || seen_cmd.blk !== want_cmd.blk ||
            seen_cmd.offset !== want_cmd.offset || seen_cmd.data !== want_cmd.data ||
            seen_cmd.mem !== want_cmd.mem || seen_cmd.last !== want_cmd.last)
          note_failure({"mismatch: expected ", cmd_text(want_cmd), " got ",
                        cmd_text(seen_cmd)});
      end
    end
  end

  initial begin
    spi_req_t    r;
    int          pick;
    logic [1:0]  act;

    rst_ni = 1'b0;
    start = 1'b0;
    action_i = '0;
    desc_index_i = '0;
    desc_length_i = '0;
    desc_has_tx_i = 1'b0;
    desc_has_rx_i = 1'b0;
    block_count_i = '0;
    rx_byte_i = '0;
    runs_left = 0;
    scan_slot = 0;
    cur_blk = '0;
    bytes_to_go = '0;
    cur_off = '0;
    cur_tx = 1'b0;
    cur_rx = 1'b0;
    run_active = 1'b0;
    items_sent = 0;
    mismatches = 0;

    // Ignored requests and an empty run straight after reset, then a full
    // table load. Slot 15 first gets the longest length and is then rewritten.
    directed_rows.push_back('{make_req(ACT_XFER_DONE, 0, 0, 0, 0, 0, 8'hFF), 1'b1, 0, NoCmd});
    directed_rows.push_back('{make_req(ACT_START, 0, 0, 0, 0, 0, 0), 1'b1, 1, DoneCmd});
    directed_rows.push_back('{make_req(ActUnused, 0, 0, 0, 0, 0, 0), 1'b1, 0, NoCmd});
    directed_rows.push_back('{make_req(ACT_WRITE, 15, 16'hFFFF, 1, 1, 0, 0), 1'b1, 0, NoCmd});
    for (int s = 0; s < MaxBlocks; s++)
      directed_rows.push_back('{make_req(ACT_WRITE, s,
                                         (s == 0) ? 2 : (s == 3 || s == 15) ? 1 : 0,
                                         s == 0, s == 0 || s == 3, 0, 0),
                                1'b1, 0, NoCmd});
    // An oversized count walks the whole table; requests that arrive in the
    // middle of the run must be ignored.
    directed_rows.push_back('{make_req(ACT_START, 0, 0, 0, 0, 31, 0), 1'b1, 1, FirstMemShift});
    directed_rows.push_back('{make_req(ACT_XFER_DONE, 0, 0, 0, 0, 0, 8'h00), 1'b0, 0, NoCmd});
    directed_rows.push_back('{make_req(ACT_WRITE, 0, 16'hFFFF, 0, 0, 0, 0), 1'b1, 0, NoCmd});
    directed_rows.push_back('{make_req(ACT_START, 0, 0, 0, 0, 1, 0), 1'b1, 0, NoCmd});
    directed_rows.push_back('{make_req(ACT_XFER_DONE, 0, 0, 0, 0, 0, 8'hFF), 1'b0, 0, NoCmd});
    directed_rows.push_back('{make_req(ACT_XFER_DONE, 0, 0, 0, 0, 0, 8'hA5), 1'b0, 0, NoCmd});
    directed_rows.push_back('{make_req(ACT_XFER_DONE, 0, 0, 0, 0, 0, 8'h5A), 1'b0, 0, NoCmd});

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].req, directed_rows[i].typed);
      if (directed_rows[i].typed && directed_rows[i].n_typed > 0)
        expected_cmds.push_back(directed_rows[i].cmd);
    end

    // Random runs: reload a few descriptors, start, then answer every shift
    // with a completion, with stray requests mixed in.
    while (items_sent < TargetRequests) begin
      repeat ($urandom_range(0, 4)) begin
        r = random_request(ACT_WRITE);
        pick = $urandom_range(0, 9);
        r.length = (pick < 3) ? 16'd0 :
                   (pick < 9) ? 16'($urandom_range(1, 4)) : 16'($urandom_range(5, 24));
        send_request(r, 1'b0);
      end
      if ($urandom_range(0, 7) == 0)
        send_request(random_request(($urandom_range(0, 1) != 0) ? ActUnused : ACT_XFER_DONE),
                     1'b0);
      r = random_request(ACT_START);
      pick = $urandom_range(0, 19);
      r.count = (pick == 0) ? CountW'($urandom_range(17, 31)) :
                (pick == 1) ? CountW'(0) : CountW'($urandom_range(1, 16));
      send_request(r, 1'b0);
      while (run_active) begin
        pick = $urandom_range(0, 19);
        case (pick)
          0:       act = ACT_WRITE;
          1:       act = ACT_START;
          2:       act = ActUnused;
          default: act = ACT_XFER_DONE;
        endcase
        send_request(random_request(act), 1'b0);
      end
    end

    start <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk_i);
    repeat (2 * MaxBlocks + 8) @(posedge clk_i);
    if (expected_cmds.size() != 0)
      note_failure($sformatf("%0d expected results never arrived", expected_cmds.size()));
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
